### rtl/plane_region_accumulator_macros.svh
// Assertion macros for the plane region accumulator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PLANE_REGION_ACCUMULATOR_MACROS_SVH
`define PLANE_REGION_ACCUMULATOR_MACROS_SVH

// Same-cycle implication.
`define PRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pra_pkg.sv
// Constants shared by the plane region accumulator.
// No dependencies.
package pra_pkg;

  localparam int unsigned AreaW = 32;
  localparam int unsigned NormW = 16;
  localparam int unsigned PosW  = 32;
  localparam int unsigned SumW  = 48;
  localparam int unsigned WcsW  = 64;
  localparam int unsigned PtolW = 32;
  localparam int unsigned NtolW = 15;

  localparam logic [PtolW-1:0] PtolReset = 32'd6554;
  localparam logic [NtolW-1:0] NtolReset = 15'd164;

  // configuration register indexes
  localparam logic CfgPtol = 1'b0;
  localparam logic CfgNtol = 1'b1;

  localparam logic [SumW-1:0] AreaMax = {SumW{1'b1}};
  localparam logic [PosW-1:0] PosMax  = 32'h7fff_ffff;
  localparam logic [PosW-1:0] PosMin  = 32'h8000_0000;

endpackage

### rtl/plane_region_accumulator.sv
// Plane region accumulator: tests and merges triangles into one fitted plane.
// Depends on pra_pkg and plane_region_accumulator_macros.svh.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o) carries one triangle request with a seed flag.
//   A seed restarts the plane. Other triangles are tested against the plane and merged
//   only if they fit.
// - Output channel (out_valid_o/out_ready_i) returns one result per request: the accept
//   flag, plane normal, area-weighted centroid and total area after the request.
// - Config channel (cfg_valid_i/cfg_ready_o) writes the point tolerance (index 0) or
//   the normal tolerance (index 1). It is always ready.
// - A seed skips the fit test. A zero normal sum skips the root and normal divide, a
//   zero total area the centroid divide. The square root takes 31 steps, the normal
//   divide 16 and the centroid divide 32. All products go through one shared 33x33
//   multiplier.
// - One request at a time: in_ready_o is high only while the sequencer is idle.
// - Results go to an output register. If the receiver stalls, the next request still
//   runs, but it waits at its end until the previous result has been taken.
// - Reset clears the plane state, loads the default tolerances and empties the output.
module plane_region_accumulator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                seed_i,
  input  logic [31:0]         tri_area_i,
  input  logic signed [15:0]  tri_normal_x_i,
  input  logic signed [15:0]  tri_normal_y_i,
  input  logic signed [15:0]  tri_normal_z_i,
  input  logic signed [31:0]  tri_center_x_i,
  input  logic signed [31:0]  tri_center_y_i,
  input  logic signed [31:0]  tri_center_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic signed [15:0]  plane_normal_x_o,
  output logic signed [15:0]  plane_normal_y_o,
  output logic signed [15:0]  plane_normal_z_o,
  output logic signed [31:0]  ref_point_x_o,
  output logic signed [31:0]  ref_point_y_o,
  output logic signed [31:0]  ref_point_z_o,
  output logic [47:0]         total_area_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

`include "plane_region_accumulator_macros.svh"

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TEST   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_WMUL   = 4'd3;
  localparam logic [3:0] S_NORM   = 4'd4;
  localparam logic [3:0] S_SQ     = 4'd5;
  localparam logic [3:0] S_SQRT   = 4'd6;
  localparam logic [3:0] S_NDIV   = 4'd7;
  localparam logic [3:0] S_CMUL   = 4'd8;
  localparam logic [3:0] S_CDIV   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_q;
  logic [5:0] cnt_q;

  logic [pra_pkg::PtolW-1:0] ptol_q;
  logic [pra_pkg::NtolW-1:0] ntol_q;

  // latched request
  logic [31:0]        area_q;
  logic signed [15:0] t_q [3];
  logic signed [31:0] c_q [3];

  // plane state
  logic signed [15:0] un_q  [3];
  logic signed [63:0] wcs_q [3];
  logic [47:0]        asum_q;
  logic signed [31:0] cen_q [3];
  logic               acc_q;

  // working registers
  logic signed [65:0] prod_q;
  logic signed [51:0] p1_q, p2_q;
  logic signed [33:0] tn_q;
  logic               vneg_q [3];
  logic [48:0]        a_q [3];
  logic [61:0]        sq_q;
  logic [61:0]        x_q;
  logic [62:0]        r_q;
  logic [47:0]        rem_q [3];
  logic [31:0]        low_q [3];
  logic [31:0]        quo_q [3];
  logic               sat_q [3];

  // output register
  logic               out_valid_q;
  logic               out_acc_q;
  logic signed [15:0] out_un_q  [3];
  logic signed [31:0] out_cen_q [3];
  logic [47:0]        out_area_q;

  // combinational
  logic signed [32:0] d [3];
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_d;
  logic signed [49:0] vb_d [3];
  logic signed [49:0] ws_d;
  logic signed [49:0] v_d [3];
  logic [48:0]        vabs_d [3];
  logic [48:0]        m_d;
  logic [51:0]        p1_abs, p2_abs, lim;
  logic [33:0]        tn_abs;
  logic signed [34:0] nt_diff, nt_lim;
  logic               fits;
  logic [62:0]        sq_b, sq_rb;
  logic               sq_ge;
  logic [47:0]        divisor;
  logic [48:0]        remsh [3];
  logic               ge [3];
  logic [47:0]        rem_nx [3];
  logic [44:0]        num_d [3];
  logic [63:0]        mag_d [3];
  logic [31:0]        cabs_d [3];
  logic [47:0]        term_d;
  logic signed [64:0] wsum_d [3];
  logic [48:0]        asum_d;
  logic [15:0]        q16 [3];

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      d[l] = $signed({c_q[l][31], c_q[l]}) - $signed({cen_q[l][31], cen_q[l]});
      cabs_d[l] = c_q[l][31] ? (~c_q[l] + 32'd1) : c_q[l];
      mag_d[l]  = wcs_q[l][63] ? (~wcs_q[l] + 64'd1) : wcs_q[l];
      vb_d[l]   = $signed({{4{un_q[l][15]}}, un_q[l], 30'b0});
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    for (int l = 0; l < 3; l++) begin
      unique case (state_q)
        S_TEST: begin
          if (cnt_q == 6'(l)) begin
            mul_a = d[l];
            mul_b = $signed({{17{un_q[l][15]}}, un_q[l]});
          end else if (cnt_q == 6'(l + 3)) begin
            mul_a = d[l];
            mul_b = $signed({{17{t_q[l][15]}}, t_q[l]});
          end else if (cnt_q == 6'(l + 6)) begin
            mul_a = $signed({{17{t_q[l][15]}}, t_q[l]});
            mul_b = $signed({{17{un_q[l][15]}}, un_q[l]});
          end
        end
        S_WMUL: begin
          if (cnt_q == 6'(l)) begin
            mul_a = $signed({{17{t_q[l][15]}}, t_q[l]});
            mul_b = $signed({1'b0, area_q});
          end
        end
        S_SQ: begin
          if (cnt_q == 6'(l)) begin
            mul_a = $signed({1'b0, a_q[l][31:0]});
            mul_b = $signed({1'b0, a_q[l][31:0]});
          end
        end
        S_CMUL: begin
          if (cnt_q == 6'(l)) begin
            mul_a = $signed({1'b0, cabs_d[l]});
            mul_b = $signed({1'b0, area_q});
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign prod_d = mul_a * mul_b;

  // normal sum: unit normal * 2^30 +/- weighted triangle normal
  assign ws_d = $signed({{2{prod_q[47]}}, prod_q[47:0]});
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      v_d[l]    = tn_q[33] ? (vb_d[l] - ws_d) : (vb_d[l] + ws_d);
      vabs_d[l] = v_d[l][49] ? (~v_d[l][48:0] + 49'd1) : v_d[l][48:0];
    end
  end

  always_comb begin
    m_d = a_q[0];
    if (a_q[1] > m_d) m_d = a_q[1];
    if (a_q[2] > m_d) m_d = a_q[2];
  end

  // fit tests
  always_comb begin
    p1_abs  = p1_q[51] ? (~p1_q + 52'd1) : p1_q;
    p2_abs  = p2_q[51] ? (~p2_q + 52'd1) : p2_q;
    lim     = {6'b0, ptol_q, 14'b0};
    tn_abs  = tn_q[33] ? (~tn_q + 34'd1) : tn_q;
    nt_diff = 35'sd268435456 - $signed({1'b0, tn_abs});
    nt_lim  = $signed({6'b0, ntol_q, 14'b0});
    fits    = (p1_abs < lim) && (p2_abs < lim) && (nt_diff < nt_lim);
  end

  // square root step: b = 4^k
  assign sq_b  = 63'd1 << {cnt_q[4:0], 1'b0};
  assign sq_rb = r_q + sq_b;
  assign sq_ge = ({1'b0, x_q} >= sq_rb);

  // shared restoring divider lanes
  assign divisor = (state_q == S_NDIV) ? {17'b0, r_q[30:0]} : asum_q;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      remsh[l]  = {rem_q[l], low_q[l][31]};
      ge[l]     = remsh[l] >= {1'b0, divisor};
      rem_nx[l] = ge[l] ? 48'(remsh[l] - {1'b0, divisor}) : remsh[l][47:0];
      num_d[l]  = {1'b0, a_q[l][29:0], 14'b0} + {15'b0, r_q[30:1]};
      q16[l]    = quo_q[l][15:0];
    end
  end

  // centre accumulation
  assign term_d = prod_q[63:16];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      wsum_d[l] = c_q[l][31] ? ($signed({wcs_q[l][63], wcs_q[l]}) - $signed({17'b0, term_d}))
                             : ($signed({wcs_q[l][63], wcs_q[l]}) + $signed({17'b0, term_d}));
    end
  end
  assign asum_d = {1'b0, asum_q} + {17'b0, area_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ptol_q      <= pra_pkg::PtolReset;
      ntol_q      <= pra_pkg::NtolReset;
      area_q      <= '0;
      asum_q      <= '0;
      acc_q       <= 1'b0;
      prod_q      <= '0;
      p1_q        <= '0;
      p2_q        <= '0;
      tn_q        <= '0;
      sq_q        <= '0;
      x_q         <= '0;
      r_q         <= '0;
      out_valid_q <= 1'b0;
      out_acc_q   <= 1'b0;
      out_area_q  <= '0;
      for (int l = 0; l < 3; l++) begin
        t_q[l]       <= '0;
        c_q[l]       <= '0;
        un_q[l]      <= '0;
        wcs_q[l]     <= '0;
        cen_q[l]     <= '0;
        vneg_q[l]    <= 1'b0;
        a_q[l]       <= '0;
        rem_q[l]     <= '0;
        low_q[l]     <= '0;
        quo_q[l]     <= '0;
        sat_q[l]     <= 1'b0;
        out_un_q[l]  <= '0;
        out_cen_q[l] <= '0;
      end
    end else begin
      prod_q <= prod_d;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pra_pkg::CfgPtol: ptol_q <= cfg_data_i;
          pra_pkg::CfgNtol: ntol_q <= cfg_data_i[14:0];
          default: begin
          end
        endcase
      end

      // S_DONE reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            area_q <= tri_area_i;
            t_q[0] <= tri_normal_x_i;
            t_q[1] <= tri_normal_y_i;
            t_q[2] <= tri_normal_z_i;
            c_q[0] <= tri_center_x_i;
            c_q[1] <= tri_center_y_i;
            c_q[2] <= tri_center_z_i;
            acc_q  <= 1'b1;
            p1_q   <= '0;
            p2_q   <= '0;
            tn_q   <= '0;
            cnt_q  <= '0;
            if (seed_i) begin
              for (int l = 0; l < 3; l++) begin
                un_q[l]  <= '0;
                wcs_q[l] <= '0;
                cen_q[l] <= '0;
              end
              asum_q  <= '0;
              state_q <= S_WMUL;
            end else begin
              state_q <= S_TEST;
            end
          end
        end

        S_TEST: begin
          for (int l = 0; l < 3; l++) begin
            if (cnt_q == 6'(l + 1)) p1_q <= p1_q + prod_q[51:0];
            if (cnt_q == 6'(l + 4)) p2_q <= p2_q + prod_q[51:0];
            if (cnt_q == 6'(l + 7)) tn_q <= tn_q + prod_q[33:0];
          end
          if (cnt_q == 6'd9) begin
            state_q <= S_DECIDE;
          end
          cnt_q <= cnt_q + 6'd1;
        end

        S_DECIDE: begin
          cnt_q <= '0;
          if (fits) begin
            state_q <= S_WMUL;
          end else begin
            acc_q   <= 1'b0;
            state_q <= S_DONE;
          end
        end

        S_WMUL: begin
          for (int l = 0; l < 3; l++) begin
            if (cnt_q == 6'(l + 1)) begin
              vneg_q[l] <= v_d[l][49];
              a_q[l]    <= vabs_d[l];
            end
          end
          if (cnt_q == 6'd3) state_q <= S_NORM;
          cnt_q <= cnt_q + 6'd1;
        end

        S_NORM: begin
          // bring the largest magnitude into [2^29, 2^30)
          cnt_q <= '0;
          if (m_d == '0) begin
            for (int l = 0; l < 3; l++) un_q[l] <= '0;
            state_q <= S_CMUL;
          end else if (m_d[48:38] != '0) begin
            for (int l = 0; l < 3; l++) a_q[l] <= a_q[l] >> 8;
          end else if (m_d[37:30] != '0) begin
            for (int l = 0; l < 3; l++) a_q[l] <= a_q[l] >> 1;
          end else if (m_d[29:21] == '0) begin
            for (int l = 0; l < 3; l++) a_q[l] <= a_q[l] << 8;
          end else if (!m_d[29]) begin
            for (int l = 0; l < 3; l++) a_q[l] <= a_q[l] << 1;
          end else begin
            sq_q    <= '0;
            state_q <= S_SQ;
          end
        end

        S_SQ: begin
          for (int l = 0; l < 3; l++) begin
            if (cnt_q == 6'(l + 1)) sq_q <= sq_q + prod_q[61:0];
          end
          if (cnt_q == 6'd4) begin
            x_q     <= sq_q;
            r_q     <= '0;
            cnt_q   <= 6'd30;
            state_q <= S_SQRT;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end

        S_SQRT: begin
          if (sq_ge) begin
            x_q <= x_q - sq_rb[61:0];
            r_q <= (r_q >> 1) + sq_b;
          end else begin
            r_q <= r_q >> 1;
          end
          if (cnt_q == '0) begin
            state_q <= S_NDIV;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end

        S_NDIV: begin
          if (cnt_q == '0) begin
            for (int l = 0; l < 3; l++) begin
              rem_q[l] <= {19'b0, num_d[l][44:16]};
              low_q[l] <= {num_d[l][15:0], 16'b0};
              quo_q[l] <= '0;
            end
            cnt_q <= cnt_q + 6'd1;
          end else if (cnt_q == 6'd17) begin
            for (int l = 0; l < 3; l++) begin
              un_q[l] <= vneg_q[l] ? $signed(~q16[l] + 16'd1) : $signed(q16[l]);
            end
            cnt_q   <= '0;
            state_q <= S_CMUL;
          end else begin
            for (int l = 0; l < 3; l++) begin
              rem_q[l] <= rem_nx[l];
              low_q[l] <= low_q[l] << 1;
              quo_q[l] <= {quo_q[l][30:0], ge[l]};
            end
            cnt_q <= cnt_q + 6'd1;
          end
        end

        S_CMUL: begin
          for (int l = 0; l < 3; l++) begin
            if (cnt_q == 6'(l + 1)) begin
              if (wsum_d[l][64] != wsum_d[l][63]) begin
                wcs_q[l] <= wsum_d[l][64] ? $signed({1'b1, 63'b0}) : $signed({1'b0, {63{1'b1}}});
              end else begin
                wcs_q[l] <= wsum_d[l][63:0];
              end
            end
          end
          if (cnt_q == 6'd4) begin
            asum_q  <= asum_d[48] ? pra_pkg::AreaMax : asum_d[47:0];
            cnt_q   <= '0;
            state_q <= S_CDIV;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end

        S_CDIV: begin
          if (cnt_q == '0) begin
            if (asum_q == '0) begin
              for (int l = 0; l < 3; l++) cen_q[l] <= c_q[l];
              state_q <= S_DONE;
            end else begin
              for (int l = 0; l < 3; l++) begin
                sat_q[l] <= (mag_d[l][63:16] >= asum_q);
                rem_q[l] <= mag_d[l][63:16];
                low_q[l] <= {mag_d[l][15:0], 16'b0};
                quo_q[l] <= '0;
              end
              cnt_q <= cnt_q + 6'd1;
            end
          end else if (cnt_q == 6'd33) begin
            for (int l = 0; l < 3; l++) begin
              if (sat_q[l]) begin
                cen_q[l] <= wcs_q[l][63] ? pra_pkg::PosMin : pra_pkg::PosMax;
              end else if (wcs_q[l][63]) begin
                cen_q[l] <= quo_q[l][31] ? pra_pkg::PosMin : (~quo_q[l] + 32'd1);
              end else begin
                cen_q[l] <= quo_q[l][31] ? pra_pkg::PosMax : quo_q[l];
              end
            end
            cnt_q   <= '0;
            state_q <= S_DONE;
          end else begin
            for (int l = 0; l < 3; l++) begin
              rem_q[l] <= rem_nx[l];
              low_q[l] <= low_q[l] << 1;
              quo_q[l] <= {quo_q[l][30:0], ge[l]};
            end
            cnt_q <= cnt_q + 6'd1;
          end
        end

        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_acc_q   <= acc_q;
            out_area_q  <= asum_q;
            for (int l = 0; l < 3; l++) begin
              out_un_q[l]  <= un_q[l];
              out_cen_q[l] <= cen_q[l];
            end
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = out_acc_q;
  assign plane_normal_x_o = out_un_q[0];
  assign plane_normal_y_o = out_un_q[1];
  assign plane_normal_z_o = out_un_q[2];
  assign ref_point_x_o    = out_cen_q[0];
  assign ref_point_y_o    = out_cen_q[1];
  assign ref_point_z_o    = out_cen_q[2];
  assign total_area_o     = out_area_q;

  `PRA_ASSERT_NEXT(in_busy_a, in_valid_i && in_ready_o, !in_ready_o,
                   "request taken but sequencer still ready")
  `PRA_ASSERT_NOW(len_range_a, state_q == S_NDIV,
                  (r_q[30:29] != 2'b00) && (r_q[62:31] == '0), "normal length out of range")
  `PRA_ASSERT_NOW(div_rem_a, (state_q == S_CDIV) && (cnt_q != '0) && !sat_q[0],
                  rem_q[0] < asum_q, "centroid divide remainder not below divisor")

endmodule

### tb/sv/plane_region_accumulator_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for plane_region_accumulator: seeded regions, noise and tolerance sweeps.
// Depends on pra_pkg and the top level; a scoreboard class predicts every result.

typedef struct {
  bit               seed;
  bit [31:0]        area;
  bit signed [15:0] nrm[3];
  bit signed [31:0] ctr[3];
} triangle_t;

typedef struct {
  bit               acc;
  bit signed [15:0] nrm[3];
  bit signed [31:0] pt[3];
  bit [47:0]        area;
} plane_t;

class plane_scoreboard;
  int unsigned       ptol = pra_pkg::PtolReset;
  int unsigned       ntol = 32'(pra_pkg::NtolReset);
  longint            unit_n[3];
  longint            wsum[3];
  longint unsigned   asum;
  longint            cen[3];
  plane_t            pending[$];
  int                errors;

  function longint unsigned mag(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function longint unsigned isqrt(longint unsigned x);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function void renorm(longint v[3]);
    longint unsigned a[3], m, sum, len;
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = mag(v[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) unit_n[i] = 0;
      return;
    end
    while (m >= (64'd1 << 30)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum += a[i] * a[i];
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      longint q;
      q = longint'((a[i] * 16384 + (len >> 1)) / len);
      unit_n[i] = v[i] < 0 ? -q : q;
    end
  endfunction

  function longint centroid_div(longint s, longint unsigned ar);
    longint unsigned mg, q0, r, frac, full;
    mg = mag(s);
    q0 = mg / ar;
    r = mg % ar;
    frac = 0;
    if (q0 >= (64'd1 << 16)) return s < 0 ? -64'sd2147483648 : 64'sd2147483647;
    for (int k = 0; k < 16; k++) begin
      r = r << 1;
      frac = frac << 1;
      if (r >= ar) begin
        r = r - ar;
        frac = frac | 1;
      end
    end
    full = (q0 << 16) | frac;
    if (s < 0) return full >= (64'd1 << 31) ? -64'sd2147483648 : -longint'(full);
    return full > 64'd2147483647 ? 64'sd2147483647 : longint'(full);
  endfunction

  function bit fits(longint t[3], longint c[3]);
    longint p1 = 0, p2 = 0, tn = 0, lim, d;
    lim = longint'(ptol) * 16384;
    for (int i = 0; i < 3; i++) begin
      d = c[i] - cen[i];
      p1 += d * unit_n[i];
      p2 += d * t[i];
      tn += t[i] * unit_n[i];
    end
    if ((p1 < 0 ? -p1 : p1) >= lim) return 0;
    if ((p2 < 0 ? -p2 : p2) >= lim) return 0;
    return ((longint'(1) << 28) - (tn < 0 ? -tn : tn)) < longint'(ntol) * 16384;
  endfunction

  function void merge(longint unsigned ar, longint t[3], longint c[3]);
    longint dot = 0, v[3], term;
    for (int i = 0; i < 3; i++) dot += unit_n[i] * t[i];
    for (int i = 0; i < 3; i++)
      v[i] = dot < 0 ? unit_n[i] * (longint'(1) << 30) - t[i] * longint'(ar)
                     : unit_n[i] * (longint'(1) << 30) + t[i] * longint'(ar);
    renorm(v);
    for (int i = 0; i < 3; i++) begin
      term = longint'((mag(c[i]) * ar) >> 16);
      if (c[i] < 0) term = -term;
      if (term > 0 && wsum[i] > 64'sh7fff_ffff_ffff_ffff - term)
        wsum[i] = 64'sh7fff_ffff_ffff_ffff;
      else if (term < 0 && wsum[i] < -64'sh7fff_ffff_ffff_ffff - 1 - term)
        wsum[i] = -64'sh7fff_ffff_ffff_ffff - 1;
      else wsum[i] += term;
    end
    asum += ar;
    if (asum > pra_pkg::AreaMax) asum = pra_pkg::AreaMax;
    for (int i = 0; i < 3; i++)
      cen[i] = asum == 0 ? c[i] : centroid_div(wsum[i], asum);
  endfunction

  function void note_triangle(triangle_t tr);
    longint t[3], c[3];
    plane_t p;
    for (int i = 0; i < 3; i++) begin
      t[i] = longint'(tr.nrm[i]);
      c[i] = longint'(tr.ctr[i]);
    end
    if (tr.seed) begin
      for (int i = 0; i < 3; i++) begin
        unit_n[i] = 0;
        wsum[i] = 0;
        cen[i] = 0;
      end
      asum = 0;
      p.acc = 1;
    end else p.acc = fits(t, c);
    if (p.acc) merge(64'(tr.area), t, c);
    for (int i = 0; i < 3; i++) begin
      p.nrm[i] = unit_n[i][15:0];
      p.pt[i] = cen[i][31:0];
    end
    p.area = asum[47:0];
    pending.insert(pending.size(), p);
  endfunction

  function void check_plane(plane_t got);
    plane_t exp_p;
    if (pending.size() == 0) begin
      $display("%0t: result with no request outstanding", $realtime);
      errors++;
      return;
    end
    exp_p = pending.pop_front();
    if (got.acc != exp_p.acc) begin
      $display("%0t: accepted exp %0d got %0d", $realtime, exp_p.acc, got.acc);
      errors++;
    end
    for (int i = 0; i < 3; i++) begin
      if (got.nrm[i] != exp_p.nrm[i]) begin
        $display("%0t: normal[%0d] exp %0d got %0d", $realtime, i, exp_p.nrm[i], got.nrm[i]);
        errors++;
      end
      if (got.pt[i] != exp_p.pt[i]) begin
        $display("%0t: ref_point[%0d] exp %0d got %0d", $realtime, i, exp_p.pt[i], got.pt[i]);
        errors++;
      end
    end
    if (got.area != exp_p.area) begin
      $display("%0t: total_area exp %0h got %0h", $realtime, exp_p.area, got.area);
      errors++;
    end
  endfunction
endclass

module plane_region_accumulator_tb;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned SettleCycles = 200;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, seed_i;
  logic [31:0] tri_area_i;
  logic signed [15:0] tri_normal_x_i, tri_normal_y_i, tri_normal_z_i;
  logic signed [31:0] tri_center_x_i, tri_center_y_i, tri_center_z_i;
  logic out_valid_o, out_ready_i, accepted_o;
  logic signed [15:0] plane_normal_x_o, plane_normal_y_o, plane_normal_z_o;
  logic signed [31:0] ref_point_x_o, ref_point_y_o, ref_point_z_o;
  logic [47:0] total_area_o;
  logic cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [31:0] cfg_data_i;

  plane_scoreboard sb;
  int burst_left;
  int hold_cycles;
  triangle_t tri_q;

  plane_region_accumulator dut (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    rst_ni = 0;
    in_valid_i = 0;
    seed_i = 0;
    tri_area_i = 0;
    {tri_normal_x_i, tri_normal_y_i, tri_normal_z_i} = '0;
    {tri_center_x_i, tri_center_y_i, tri_center_z_i} = '0;
    out_ready_i = 0;
    cfg_valid_i = 0;
    cfg_index_i = pra_pkg::CfgPtol;
    cfg_data_i = 0;
    hold_cycles = 0;
    burst_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
  end

  function automatic int srand(int k);
    return int'($urandom_range(0, 2 * k)) - k;
  endfunction

  // input monitor: fields are bench registers, so pre-edge values are read here
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      triangle_t tr;
      tr.seed = seed_i;
      tr.area = tri_area_i;
      tr.nrm[0] = tri_normal_x_i;
      tr.nrm[1] = tri_normal_y_i;
      tr.nrm[2] = tri_normal_z_i;
      tr.ctr[0] = tri_center_x_i;
      tr.ctr[1] = tri_center_y_i;
      tr.ctr[2] = tri_center_z_i;
      sb.note_triangle(tr);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      plane_t p;
      p.acc = accepted_o;
      p.nrm[0] = plane_normal_x_o;
      p.nrm[1] = plane_normal_y_o;
      p.nrm[2] = plane_normal_z_o;
      p.pt[0] = ref_point_x_o;
      p.pt[1] = ref_point_y_o;
      p.pt[2] = ref_point_z_o;
      p.area = total_area_o;
      sb.check_plane(p);
    end
  end

  // receiver: random stall patterns; long hold-off on request
  initial begin
    int mode, cnt;
    mode = 0;
    cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 0;
      end else begin
        if (++cnt == 300) begin
          cnt = 0;
          mode = $urandom_range(0, 3);
        end
        case (mode)
          0: out_ready_i <= 1;
          1: out_ready_i <= $urandom_range(0, 1);
          2: out_ready_i <= ($urandom_range(0, 7) == 0);
          default: out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) idle = 0;
      else if (++idle >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send(triangle_t tr);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 40));
      if (gap > 0) begin
        in_valid_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    seed_i <= tr.seed;
    tri_area_i <= tr.area;
    tri_normal_x_i <= tr.nrm[0];
    tri_normal_y_i <= tr.nrm[1];
    tri_normal_z_i <= tr.nrm[2];
    tri_center_x_i <= tr.ctr[0];
    tri_center_y_i <= tr.ctr[1];
    tri_center_z_i <= tr.ctr[2];
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == pra_pkg::CfgPtol) sb.ptol = data;
    else sb.ntol = 32'(data[14:0]);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic triangle_t make_tri(bit sd, bit [31:0] ar, int nx, int ny, int nz,
                                         int cx, int cy, int cz);
    triangle_t tr;
    tr.seed = sd;
    tr.area = ar;
    tr.nrm[0] = 16'(nx);
    tr.nrm[1] = 16'(ny);
    tr.nrm[2] = 16'(nz);
    tr.ctr[0] = cx;
    tr.ctr[1] = cy;
    tr.ctr[2] = cz;
    return tr;
  endfunction

  function automatic triangle_t noise_tri();
    triangle_t tr;
    tr.seed = $urandom_range(0, 3) == 0;
    tr.area = $urandom;
    for (int i = 0; i < 3; i++) begin
      tr.nrm[i] = 16'($urandom);
      tr.ctr[i] = $urandom;
    end
    return tr;
  endfunction

  // a seed on an axis-aligned plane, then triangles close to it, mixed with noise and outliers
  task automatic grow_region(int count);
    int ax, sg, base[3], off;
    triangle_t tr;
    ax = $urandom_range(0, 2);
    sg = $urandom_range(0, 1) ? 1 : -1;
    for (int i = 0; i < 3; i++) base[i] = srand(1 << 24);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        send(noise_tri());
        continue;
      end
      tr.seed = (k == 0);
      case ($urandom_range(0, 9))
        0: tr.area = $urandom;
        1: tr.area = 0;
        default: tr.area = $urandom_range(1, 1 << 20);
      endcase
      for (int i = 0; i < 3; i++) begin
        tr.nrm[i] = 16'(srand(24));
        tr.ctr[i] = base[i] + srand(1 << 18);
      end
      tr.nrm[ax] = 16'(sg * (16384 - int'($urandom_range(0, 60))));
      if ($urandom_range(0, 4) == 0) for (int i = 0; i < 3; i++) tr.nrm[i] = -tr.nrm[i];
      off = sb.ptol >> 2;
      if (off > (1 << 20)) off = 1 << 20;
      tr.ctr[ax] = base[ax] + srand(off);
      if ($urandom_range(0, 14) == 0) tr.ctr[ax] = base[ax] + srand(1 << 22);
      send(tr);
    end
  endtask

  initial begin
    int unsigned ptols[5] = '{32'd0, 32'hffff_ffff, 32'd131072, 32'd655, 32'd6554};
    int unsigned ntols[5] = '{0, 16384, 2000, 16, 164};
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // before any seed, then seed corner cases
    send(make_tri(0, 32'd65536, 0, 0, 16384, 0, 0, 0));
    send(make_tri(0, 32'd65536, 16384, 0, 0, 100, 0, 0));
    send(make_tri(1, 32'd0, 0, 0, 16384, 32'h7fff_ffff, -32'sd5, 32'h8000_0000));
    send(make_tri(0, 32'd0, 0, 0, 16384, 0, 0, -32'sh8000_0000));
    send(make_tri(1, 32'd1000, 0, 0, 0, 1, 2, 3));
    send(make_tri(0, 32'd1000, 0, 0, 0, 1, 2, 3));
    send(make_tri(1, 32'hffff_ffff, -16384, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0));
    send(make_tri(0, 32'hffff_ffff, -16384, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0));
    send(make_tri(0, 32'hffff_ffff, 16384, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0));
    send(make_tri(1, 32'hffff_ffff, 0, -32768, 32767, 32'h8000_0000, 32'h8000_0000, -1));
    send(make_tri(0, 32'hffff_ffff, 0, -32768, 32767, 32'h8000_0000, 32'h8000_0000, -1));
    send(make_tri(1, 32'd65536, 0, 16384, 0, 0, 65536, 0));
    send(make_tri(0, 32'd65536, 0, -16384, 0, 65536, 65536, 0));
    send(make_tri(0, 32'd65536, 0, 16384, 0, 0, 65536 + 6554, 0));
    send(make_tri(0, 32'd65536, 0, 16384, 0, 0, 65536 + 6553, 0));
    send(make_tri(0, 32'd1, 164, 16383, 0, 0, 65536, 0));
    send(make_tri(0, 32'd1, 16384, 16384, 16384, -1, -1, -1));
    send(make_tri(0, 32'hffff_ffff, -1, -1, -1, 32'h7fff_ffff, -1, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      int made;
      if (ph > 0) begin
        write_reg(pra_pkg::CfgPtol, ptols[ph - 1]);
        write_reg(pra_pkg::CfgNtol, ntols[ph - 1]);
      end
      made = 0;
      while (made < 300) begin
        int len;
        len = $urandom_range(3, 30);
        if (ph == 2 && made == 100) hold_cycles = 3000;
        grow_region(len);
        made += len;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/pra_pkg.sv
rtl/plane_region_accumulator.sv
tb/sv/plane_region_accumulator_tb.sv
